/* rtl/core/gntm_pkg.sv */
package gntm_pkg;

	localparam int MAX_TARGETS_DEF = 64;
	localparam int POS_W = 16;
	localparam int ID_W = 16;
	localparam int GATE_W = 16;
	localparam int MIDX_W = 6;
	localparam int SQ_W = 2 * POS_W;
	localparam int DIST_W = SQ_W + 1;
	localparam int DIST_LAT = 3;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_MATCH = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [ID_W-1:0]         target_id;
	} req_t;

	typedef struct packed {
		logic              matched;
		logic [MIDX_W-1:0] match_index;
		logic [ID_W-1:0]   match_id;
	} rsp_t;

	typedef struct packed {
		logic                    used;
		logic                    mark;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [ID_W-1:0]         id;
	} cell_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic load;
		logic mark_set;
	} cell_ctl_t;

endpackage

/* rtl/core/gntm_cell.sv */
module gntm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  gntm_pkg::cell_ctl_t ctl,
	input  gntm_pkg::cell_t   load_data,
	input  gntm_pkg::cell_t   shift_in,
	output gntm_pkg::cell_t   q
);
	import gntm_pkg::*;

	logic                    used_q;
	logic                    mark_q;
	logic signed [POS_W-1:0] x_q;
	logic signed [POS_W-1:0] y_q;
	logic [ID_W-1:0]         id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			mark_q <= 1'b0;
		end else if (ctl.clear) begin
			used_q <= 1'b0;
			mark_q <= 1'b0;
		end else if (ctl.load) begin
			used_q <= 1'b1;
			mark_q <= 1'b0;
		end else if (ctl.shift) begin
			used_q <= shift_in.used;
			mark_q <= shift_in.mark;
		end else if (ctl.mark_set) begin
			mark_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q  <= load_data.x;
			y_q  <= load_data.y;
			id_q <= load_data.id;
		end else if (ctl.shift) begin
			x_q  <= shift_in.x;
			y_q  <= shift_in.y;
			id_q <= shift_in.id;
		end
	end

	assign q = '{used: used_q, mark: mark_q, x: x_q, y: y_q, id: id_q};

endmodule

/* rtl/core/gntm_dist.sv */
module gntm_dist #(
	parameter int IDX_W = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cand,
	input  logic [IDX_W-1:0]               idx,
	input  logic [gntm_pkg::ID_W-1:0]      id,
	input  logic signed [gntm_pkg::POS_W-1:0] tx,
	input  logic signed [gntm_pkg::POS_W-1:0] ty,
	input  logic signed [gntm_pkg::POS_W-1:0] qx,
	input  logic signed [gntm_pkg::POS_W-1:0] qy,
	output logic                           cand_o,
	output logic [IDX_W-1:0]               idx_o,
	output logic [gntm_pkg::ID_W-1:0]      id_o,
	output logic [gntm_pkg::DIST_W-1:0]    dist_o
);
	import gntm_pkg::*;

	logic signed [POS_W:0]     dx_s1, dy_s1;
	logic signed [2*POS_W+1:0] px, py;
	logic [SQ_W-1:0]           sqx_s2, sqy_s2;
	logic [DIST_W-1:0]         dist_s3;
	logic                      cand_s1, cand_s2, cand_s3;
	logic [IDX_W-1:0]          idx_s1, idx_s2, idx_s3;
	logic [ID_W-1:0]           id_s1, id_s2, id_s3;

	assign px = (2*POS_W+2)'(dx_s1) * (2*POS_W+2)'(dx_s1);
	assign py = (2*POS_W+2)'(dy_s1) * (2*POS_W+2)'(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_s1 <= 1'b0;
			cand_s2 <= 1'b0;
			cand_s3 <= 1'b0;
		end else begin
			cand_s1 <= cand;
			cand_s2 <= cand_s1;
			cand_s3 <= cand_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= $signed({tx[POS_W-1], tx}) - $signed({qx[POS_W-1], qx});
		dy_s1   <= $signed({ty[POS_W-1], ty}) - $signed({qy[POS_W-1], qy});
		idx_s1  <= idx;
		id_s1   <= id;
		sqx_s2  <= px[SQ_W-1:0];
		sqy_s2  <= py[SQ_W-1:0];
		idx_s2  <= idx_s1;
		id_s2   <= id_s1;
		dist_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		idx_s3  <= idx_s2;
		id_s3   <= id_s2;
	end

	assign cand_o = cand_s3;
	assign idx_o  = idx_s3;
	assign id_o   = id_s3;
	assign dist_o = dist_s3;

endmodule

/* rtl/core/gated_nearest_target_matcher.sv */
// Nearest-target matcher. Targets sit in a ring of MAX_TARGETS cells. A clear or a load
// request leaves the matcher idle. A match request rotates the ring once, one cell per
// cycle past a three-stage squared-distance pipeline, then waits for the pipeline to
// drain and decides the match; the response is registered when the match is decided,
// and the matcher then returns to idle for the next request. No new request is taken
// while a query is in progress, though a response may still be waiting at the output,
// and a query cannot finish while the previous response is still waiting. The nearest
// unassigned target wins, lowest index on a tie; it is marked and reported if its
// distance is within the gate written through gate_wdata (0 means no gate).
// Write gate_wdata with gate_we only while no query is in progress.
module gated_nearest_target_matcher #(
	parameter int MAX_TARGETS = gntm_pkg::MAX_TARGETS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gntm_pkg::req_t                in_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gntm_pkg::rsp_t                out_rsp,
	input  logic                          gate_we,
	input  logic [gntm_pkg::GATE_W-1:0]   gate_wdata
);
	import gntm_pkg::*;

	localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int CNT_W = $clog2(MAX_TARGETS + 1);

	state_t state_q, state_d;

	logic [GATE_W-1:0]       gate_q;
	logic [2*GATE_W-1:0]     gate_sq_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        step_q;
	logic [1:0]              drain_q;
	logic signed [POS_W-1:0] qx_q, qy_q;

	logic                    found_q;
	logic [DIST_W-1:0]       best_d_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic [ID_W-1:0]         best_id_q;

	logic                    out_valid_q;
	rsp_t                    out_rsp_q;

	cell_t                   cell_q [MAX_TARGETS];
	cell_ctl_t               cell_ctl [MAX_TARGETS];
	cell_t                   load_data;
	logic [MAX_TARGETS-1:0]  marks;

	logic                    accept, do_clear, do_load, do_query;
	logic                    scan_shift, finish, hit;

	logic                    p_cand;
	logic [IDX_W-1:0]        p_idx;
	logic [ID_W-1:0]         p_id;
	logic [DIST_W-1:0]       p_dist;
	logic                    better;
	logic [IDX_W+MIDX_W-1:0] idx_ext;

	assign accept   = in_valid && in_ready;
	assign do_clear = accept && (in_req.func == FUNC_CLEAR);
	assign do_load  = accept && (in_req.func == FUNC_LOAD) && (count_q < CNT_W'(MAX_TARGETS));
	assign do_query = accept && (in_req.func == FUNC_MATCH);

	assign hit = found_q && ((gate_q == '0) || (best_d_q <= {1'b0, gate_sq_q}));

	// control
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		scan_shift = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (in_req.func == FUNC_MATCH)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_shift = 1'b1;
				if (step_q == CNT_W'(MAX_TARGETS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == 2'(DIST_LAT - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q  <= '0;
			count_q <= '0;
			step_q  <= '0;
			drain_q <= '0;
		end else begin
			if (gate_we) begin
				gate_q <= gate_wdata;
			end
			if (do_clear) begin
				count_q <= '0;
			end else if (do_load) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (do_query) begin
				step_q <= '0;
			end else if (scan_shift) begin
				step_q <= step_q + CNT_W'(1);
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + 2'd1;
			end else begin
				drain_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_query) begin
			qx_q      <= in_req.pos_x;
			qy_q      <= in_req.pos_y;
			gate_sq_q <= (2*GATE_W)'(gate_q) * (2*GATE_W)'(gate_q);
		end
	end

	// ring of target cells
	assign load_data = '{used: 1'b1, mark: 1'b0, x: in_req.pos_x, y: in_req.pos_y,
		id: in_req.target_id};

	for (genvar i = 0; i < MAX_TARGETS; i++) begin : g_cell
		assign cell_ctl[i] = '{
			shift:    scan_shift,
			clear:    do_clear,
			load:     do_load && (count_q == CNT_W'(i)),
			mark_set: finish && hit && (best_idx_q == IDX_W'(i))
		};
		assign marks[i] = cell_q[i].mark;

		gntm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl[i]),
			.load_data (load_data),
			.shift_in  (cell_q[(i + 1) % MAX_TARGETS]),
			.q         (cell_q[i])
		);
	end

	gntm_dist #(
		.IDX_W (IDX_W)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (scan_shift && cell_q[0].used && !cell_q[0].mark),
		.idx    (step_q[IDX_W-1:0]),
		.id     (cell_q[0].id),
		.tx     (cell_q[0].x),
		.ty     (cell_q[0].y),
		.qx     (qx_q),
		.qy     (qy_q),
		.cand_o (p_cand),
		.idx_o  (p_idx),
		.id_o   (p_id),
		.dist_o (p_dist)
	);

	// best candidate so far
	assign better = p_cand && (!found_q || (p_dist < best_d_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (do_query) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_d_q   <= p_dist;
			best_idx_q <= p_idx;
			best_id_q  <= p_id;
		end
	end

	// response register
	assign idx_ext = {{MIDX_W{1'b0}}, best_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_rsp_q.matched     <= hit;
			out_rsp_q.match_index <= hit ? idx_ext[MIDX_W-1:0] : '0;
			out_rsp_q.match_id    <= hit ? best_id_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TARGETS))
		else $error("target count beyond table size");

	a_full_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && state_d == ST_DRAIN) |-> step_q == CNT_W'(MAX_TARGETS - 1))
		else $error("ring left scan before a full turn");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("response raised outside finish");

	a_mark_set: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && hit) |=> marks[$past(best_idx_q)])
		else $error("matched target not marked");

	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		p_cand |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("candidate outside a query");

endmodule
